### design/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and codes for the k-way merge min-heap block.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int RUN_WIDTH = 4;

   typedef enum logic [1:0] {
      CMD_LOAD      = 2'd0,
      CMD_START     = 2'd1,
      CMD_REFILL    = 2'd2,
      CMD_EXHAUSTED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_EMIT = 2'd0,
      STATUS_DONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_STEP,
      ST_POP_READ,
      ST_POP_LOAD,
      ST_DN_READ,
      ST_DN_STEP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic ins_setup;
      logic use_popped;
      logic emit_full;
      logic emit_done;
      logic up_read;
      logic up_move;
      logic put_x;
      logic pop_read;
      logic pop_load;
      logic dn_read;
      logic dn_move;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic x_above_parent;
      logic has_left;
      logic x_best;
   } dp_status_type;

endpackage

### design/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### design/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath
// Heap storage, moving entry and index registers, ordering compares and
// the result register.
// ----------------------------------------------------------------------------
module kwm_datapath #(
   parameter int MAX_RUNS   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kwm_pkg::dp_cmd_type                 cmd,
   output kwm_pkg::dp_status_type              status,
   input  logic signed [DATA_WIDTH-1:0]        req_value,
   input  logic [kwm_pkg::RUN_WIDTH-1:0]       req_run,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic signed [DATA_WIDTH-1:0]        rsp_out_value,
   output logic [kwm_pkg::RUN_WIDTH-1:0]       rsp_out_run
);

   localparam int IDX_W   = $clog2(MAX_RUNS);
   localparam int CNT_W   = $clog2(MAX_RUNS + 1);
   localparam int CH_W    = IDX_W + 2;
   localparam int RW      = kwm_pkg::RUN_WIDTH;
   localparam int ENTRY_W = DATA_WIDTH + RW;

   // entry layout: run above value
   function automatic logic before_f(input logic [ENTRY_W-1:0] a,
                                     input logic [ENTRY_W-1:0] b);
      logic signed [DATA_WIDTH-1:0] va;
      logic signed [DATA_WIDTH-1:0] vb;
      va = a[DATA_WIDTH-1:0];
      vb = b[DATA_WIDTH-1:0];
      return (va < vb) ||
             ((va == vb) && (a[ENTRY_W-1:DATA_WIDTH] < b[ENTRY_W-1:DATA_WIDTH]));
   endfunction

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [RW-1:0]      popped_run_ff, popped_run_in;
   logic [ENTRY_W-1:0] x_ff, x_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [RW-1:0]             rsp_run_ff, rsp_run_in;

   logic [ENTRY_W-1:0] rd_a, rd_b;
   logic [IDX_W-1:0]   parent_idx;
   logic [CH_W-1:0]    left_idx, right_idx, count_ext;
   logic [CNT_W-1:0]   count_dec;
   logic               left_first, right_first, has_right;
   logic [ENTRY_W-1:0] cand, child;
   logic [IDX_W-1:0]   child_idx;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [ENTRY_W-1:0] wr_data;

   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign left_idx   = {1'b0, idx_ff, 1'b1};
   assign right_idx  = left_idx + CH_W'(1);
   assign count_ext  = CH_W'(count_ff);
   assign count_dec  = count_ff - CNT_W'(1);

   // sift-down choice: left only if strictly ahead of x, right if ahead of that
   assign has_right   = right_idx < count_ext;
   assign left_first  = before_f(rd_a, x_ff);
   assign cand        = left_first ? rd_a : x_ff;
   assign right_first = has_right && before_f(rd_b, cand);
   assign child       = right_first ? rd_b : rd_a;
   assign child_idx   = right_first ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

   always_comb begin
      status.full           = (count_ff == CNT_W'(MAX_RUNS));
      status.empty          = (count_ff == '0);
      status.at_root        = (idx_ff == '0);
      status.x_above_parent = before_f(x_ff, rd_a);
      status.has_left       = left_idx < count_ext;
      status.x_best         = !left_first && !right_first;
   end

   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      if (cmd.up_read) begin
         rd_addr_a = parent_idx;
      end else if (cmd.pop_read) begin
         rd_addr_b = count_dec[IDX_W-1:0];
      end else if (cmd.dn_read) begin
         rd_addr_a = left_idx[IDX_W-1:0];
         rd_addr_b = right_idx[IDX_W-1:0];
      end
   end

   always_comb begin
      wr_en   = cmd.up_move || cmd.put_x || cmd.dn_move;
      wr_addr = idx_ff;
      if (cmd.put_x) begin
         wr_data = x_ff;
      end else if (cmd.up_move) begin
         wr_data = rd_a;
      end else begin
         wr_data = child;
      end
   end

   kwm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RUNS)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_comb begin
      count_in      = count_ff;
      popped_run_in = popped_run_ff;
      x_in          = x_ff;
      idx_in        = idx_ff;
      if (cmd.ins_setup) begin
         x_in     = {(cmd.use_popped ? popped_run_ff : req_run), req_value};
         idx_in   = count_ff[IDX_W-1:0];
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.up_move) begin
         idx_in = parent_idx;
      end
      if (cmd.pop_read) begin
         count_in = count_dec;
      end
      if (cmd.pop_load) begin
         popped_run_in = rd_a[ENTRY_W-1:DATA_WIDTH];
         x_in          = rd_b;
         idx_in        = '0;
      end
      if (cmd.dn_move) begin
         idx_in = child_idx;
      end
   end

   always_comb begin
      rsp_valid_in  = cmd.emit_full || cmd.emit_done || cmd.pop_load;
      rsp_status_in = kwm_pkg::STATUS_FULL;
      rsp_value_in  = '0;
      rsp_run_in    = '0;
      if (cmd.pop_load) begin
         rsp_status_in = kwm_pkg::STATUS_EMIT;
         rsp_value_in  = rd_a[DATA_WIDTH-1:0];
         rsp_run_in    = rd_a[ENTRY_W-1:DATA_WIDTH];
      end else if (cmd.emit_done) begin
         rsp_status_in = kwm_pkg::STATUS_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         popped_run_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         popped_run_ff <= popped_run_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_run_ff    <= rsp_run_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_run   = rsp_run_ff;

endmodule

### design/kwm_controller.sv
// ----------------------------------------------------------------------------
// kwm_controller
// Sequencer for heap insert, pop and the sift walks.
// ----------------------------------------------------------------------------
module kwm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_command,
   input  kwm_pkg::dp_status_type status,
   output kwm_pkg::dp_cmd_type    cmd,
   output logic                   busy
);

   kwm_pkg::state_type state_ff, state_in;
   logic               refill_ff, refill_in;
   logic               accept;

   assign accept = start && (state_ff == kwm_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in  = state_ff;
      refill_in = refill_ff;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (accept) begin
               case (kwm_pkg::cmd_type'(req_command))
                  kwm_pkg::CMD_LOAD, kwm_pkg::CMD_REFILL: begin
                     refill_in = (req_command == kwm_pkg::CMD_REFILL);
                     if (!status.full) begin
                        state_in = kwm_pkg::ST_UP_READ;
                     end
                  end
                  default: begin
                     state_in = kwm_pkg::ST_POP_READ;
                  end
               endcase
            end
         end
         kwm_pkg::ST_UP_READ: begin
            if (status.at_root) begin
               state_in = refill_ff ? kwm_pkg::ST_POP_READ : kwm_pkg::ST_IDLE;
            end else begin
               state_in = kwm_pkg::ST_UP_STEP;
            end
         end
         kwm_pkg::ST_UP_STEP: begin
            if (status.x_above_parent) begin
               state_in = kwm_pkg::ST_UP_READ;
            end else begin
               state_in = refill_ff ? kwm_pkg::ST_POP_READ : kwm_pkg::ST_IDLE;
            end
         end
         kwm_pkg::ST_POP_READ: begin
            state_in = status.empty ? kwm_pkg::ST_IDLE : kwm_pkg::ST_POP_LOAD;
         end
         kwm_pkg::ST_POP_LOAD: begin
            state_in = status.empty ? kwm_pkg::ST_IDLE : kwm_pkg::ST_DN_READ;
         end
         kwm_pkg::ST_DN_READ: begin
            state_in = status.has_left ? kwm_pkg::ST_DN_STEP : kwm_pkg::ST_IDLE;
         end
         kwm_pkg::ST_DN_STEP: begin
            state_in = status.x_best ? kwm_pkg::ST_IDLE : kwm_pkg::ST_DN_READ;
         end
         default: begin
            state_in = kwm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != kwm_pkg::ST_IDLE);
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (accept && ((req_command == kwm_pkg::CMD_LOAD) ||
                           (req_command == kwm_pkg::CMD_REFILL))) begin
               cmd.use_popped = (req_command == kwm_pkg::CMD_REFILL);
               cmd.emit_full  = status.full;
               cmd.ins_setup  = !status.full;
            end
         end
         kwm_pkg::ST_UP_READ: begin
            cmd.put_x   = status.at_root;
            cmd.up_read = !status.at_root;
         end
         kwm_pkg::ST_UP_STEP: begin
            cmd.up_move = status.x_above_parent;
            cmd.put_x   = !status.x_above_parent;
         end
         kwm_pkg::ST_POP_READ: begin
            cmd.emit_done = status.empty;
            cmd.pop_read  = !status.empty;
         end
         kwm_pkg::ST_POP_LOAD: begin
            cmd.pop_load = 1'b1;
         end
         kwm_pkg::ST_DN_READ: begin
            cmd.dn_read = status.has_left;
            cmd.put_x   = !status.has_left;
         end
         kwm_pkg::ST_DN_STEP: begin
            cmd.dn_move = !status.x_best;
            cmd.put_x   = status.x_best;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kwm_pkg::ST_IDLE;
         refill_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         refill_ff <= refill_in;
      end
   end

endmodule

### design/k_way_merge_min_heap.sv
// ----------------------------------------------------------------------------
// k_way_merge_min_heap
// K-way merge through a min-heap of (value, run) pairs, ties to lower run.
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  request   req_command, req_value, req_run            start && !busy
//  response  rsp_status, rsp_out_value, rsp_out_run     rsp_valid, one cycle
//
//  one item at a time; busy is high while the heap walk runs
//  load: sifts the new entry up from the last slot; rejected with FULL if full
//  start/exhausted: DONE on an empty heap, otherwise emits the root, moves the
//  last entry to the root and sifts it down
//  refill: a load with the run last popped, then a pop; rejected refill FULL
//  synchronous reset empties the heap; the receiver cannot stall results
// ----------------------------------------------------------------------------
module k_way_merge_min_heap #(
   parameter int MAX_RUNS   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_command,
   input  logic signed [DATA_WIDTH-1:0]       req_value,
   input  logic [kwm_pkg::RUN_WIDTH-1:0]      req_run,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic signed [DATA_WIDTH-1:0]       rsp_out_value,
   output logic [kwm_pkg::RUN_WIDTH-1:0]      rsp_out_run
);

   kwm_pkg::dp_cmd_type    dp_cmd;
   kwm_pkg::dp_status_type dp_status;

   kwm_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (dp_status),
      .cmd         (dp_cmd),
      .busy        (busy)
   );

   kwm_datapath #(
      .MAX_RUNS   (MAX_RUNS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (dp_cmd),
      .status        (dp_status),
      .req_value     (req_value),
      .req_run       (req_run),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_out_run   (rsp_out_run)
   );

endmodule

### design/kwm_checker.sv
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks on the merge heap, bound to the top level.
// ----------------------------------------------------------------------------
module kwm_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [1:0]                    req_command,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [DATA_WIDTH-1:0]         rsp_out_value,
   input logic [kwm_pkg::RUN_WIDTH-1:0] rsp_out_run
);

   // a result follows an accepted transaction or work in progress
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy) || $past(busy))
      else $error("result without a transaction");

   a_no_payload_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != kwm_pkg::STATUS_EMIT)
         |-> (rsp_out_value == '0) && (rsp_out_run == '0))
      else $error("payload not zero on status result");

   a_full_after_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == kwm_pkg::STATUS_FULL)
         |-> $past(start && !busy &&
                   ((req_command == kwm_pkg::CMD_LOAD) ||
                    (req_command == kwm_pkg::CMD_REFILL))))
      else $error("overflow status without an insert");

   a_done_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == kwm_pkg::STATUS_DONE) |-> $past(busy))
      else $error("finished status too early");

   a_pop_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && ((req_command == kwm_pkg::CMD_START) ||
                         (req_command == kwm_pkg::CMD_EXHAUSTED))
         |=> busy && !rsp_valid)
      else $error("pop transaction not started");

endmodule

bind k_way_merge_min_heap kwm_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_kwm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_out_value (rsp_out_value),
   .rsp_out_run   (rsp_out_run)
);
